FILE: rtl/rasq_pkg.sv
`timescale 1ns / 1ps

package rasq_pkg;

    localparam int SIZE_W      = 26;
    localparam int ALLOC_W     = 28;
    localparam int BUCKET_W    = 5;
    localparam int MODE_W      = 2;
    localparam int FACTOR_W    = 14;
    localparam int REG_INDEX_W = 2;
    localparam int CLASS_W     = 25;
    localparam int PRODUCT_W   = SIZE_W + FACTOR_W;
    localparam int Q_SHIFT     = 12;

    typedef logic [SIZE_W-1:0]      size_t;
    typedef logic [ALLOC_W-1:0]     alloc_t;
    typedef logic [BUCKET_W-1:0]    bucket_t;
    typedef logic [MODE_W-1:0]      mode_t;
    typedef logic [FACTOR_W-1:0]    factor_t;
    typedef logic [REG_INDEX_W-1:0] reg_index_t;
    typedef logic [CLASS_W-1:0]     class_t;
    typedef logic [PRODUCT_W-1:0]   product_t;

    localparam int CLASS_COUNT = 19;
    localparam bucket_t LAST_CLASS = bucket_t'(CLASS_COUNT - 1);

    localparam class_t CLASS_BYTES [CLASS_COUNT] = '{
        25'h0000020, 25'h0000040, 25'h0000080, 25'h0000100,
        25'h0000200, 25'h0000400, 25'h0000800, 25'h0001000,
        25'h0002000, 25'h0004000, 25'h0008000, 25'h0010000,
        25'h0020000, 25'h0040000, 25'h0080000, 25'h0100000,
        25'h0200000, 25'h0400000, 25'h1000000
    };

    localparam size_t LARGE_LIMIT = size_t'(26'h0400000);
    localparam size_t LARGE_MASK  = size_t'(26'h003FFFF);
    localparam size_t MB_MASK     = size_t'(26'h00FFFFF);

    localparam factor_t Q_ONE = factor_t'(4096);

    localparam mode_t MODE_EXACT     = 2'd0;
    localparam mode_t MODE_POW2      = 2'd1;
    localparam mode_t MODE_PADDING   = 2'd2;
    localparam mode_t MODE_SIXTEENTH = 2'd3;

    localparam reg_index_t REG_SIZE_MODE      = 2'd0;
    localparam reg_index_t REG_PADDING_FACTOR = 2'd1;

    function automatic class_t class_size(bucket_t idx);
        class_t bytes;
        if (idx > LAST_CLASS)
        begin
            bytes = CLASS_BYTES[CLASS_COUNT-1];
        end
        else
        begin
            bytes = CLASS_BYTES[idx];
        end
        return bytes;
    endfunction

endpackage

FILE: rtl/record_allocation_size_quantizer_top.sv
`timescale 1ns / 1ps

// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+---------------------------
// request   | request_size                           | start && !busy
// result    | alloc_size, bucket_index               | done, one cycle, no stall
// config    | wr_index, wr_data                      | wr_en
//
// One request per cycle; each request passes the input register, then the class
// compare, the Q2.12 multiply and the truncation into the result register.
// busy is always low, since the receiver never stalls and nothing iterates.
// rst_n clears the valid flags and returns size_mode to padding and
// padding_factor to 1.0.

module record_allocation_size_quantizer_top
    import rasq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  size_t      request_size,
    output logic       done,
    output alloc_t     alloc_size,
    output bucket_t    bucket_index,
    input  logic       wr_en,
    input  reg_index_t wr_index,
    input  factor_t    wr_data
);

    mode_t   size_mode_reg;
    factor_t padding_factor_reg;

    logic    req_valid_reg;
    size_t   req_size_reg;

    logic    done_reg;
    alloc_t  alloc_size_reg;
    bucket_t bucket_index_reg;

    bucket_t  bucket_next;
    alloc_t   alloc_next;
    class_t   class_bytes;
    size_t    unit_mask;
    factor_t  factor_eff;
    product_t product;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_mode_reg      <= MODE_PADDING;
            padding_factor_reg <= Q_ONE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SIZE_MODE:      size_mode_reg      <= wr_data[MODE_W-1:0];
                REG_PADDING_FACTOR: padding_factor_reg <= wr_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_size_reg <= request_size;
        end
        if (req_valid_reg)
        begin
            alloc_size_reg   <= alloc_next;
            bucket_index_reg <= bucket_next;
        end
    end

    // Bucket is the count of classes at or below the request, capped at the last.
    always_comb
    begin
        bucket_next = '0;
        for (int i = 0; i < CLASS_COUNT - 1; i++)
        begin
            if (SIZE_W'(CLASS_BYTES[i]) <= req_size_reg)
            begin
                bucket_next = bucket_t'(i + 1);
            end
        end
    end

    assign class_bytes = class_size(bucket_next);
    assign factor_eff  = (padding_factor_reg < Q_ONE) ? Q_ONE : padding_factor_reg;
    assign product     = PRODUCT_W'(req_size_reg) * PRODUCT_W'(factor_eff);

    // Below the large limit the bucket is a power of two, so its sixteenth minus one.
    assign unit_mask = (req_size_reg >= LARGE_LIMIT) ? LARGE_MASK
                     : SIZE_W'((class_bytes >> 4) - class_t'(1));

    always_comb
    begin
        case (size_mode_reg)
            MODE_EXACT:
            begin
                alloc_next = ALLOC_W'(req_size_reg);
            end
            MODE_POW2:
            begin
                if (bucket_next == LAST_CLASS)
                begin
                    alloc_next = ALLOC_W'(req_size_reg | MB_MASK) + alloc_t'(1);
                end
                else
                begin
                    alloc_next = ALLOC_W'(class_bytes);
                end
            end
            MODE_PADDING:
            begin
                alloc_next = product[Q_SHIFT +: ALLOC_W];
            end
            default:
            begin
                if ((req_size_reg & unit_mask) == '0)
                begin
                    alloc_next = ALLOC_W'(req_size_reg);
                end
                else
                begin
                    alloc_next = ALLOC_W'(req_size_reg | unit_mask) + alloc_t'(1);
                end
            end
        endcase
    end

    assign done         = done_reg;
    assign alloc_size   = alloc_size_reg;
    assign bucket_index = bucket_index_reg;

endmodule
